/* rtl/shp3_pkg.sv */
// shared constants and types of the 3x3 sharpen stream
package shp3_pkg;

  // line buffer geometry
  localparam int MaxWidth    = 2048;
  localparam int MaxChannels = 4;
  localparam int LineDepth   = MaxWidth * MaxChannels;
  localparam int AddrW       = $clog2(LineDepth);
  localparam int LenW        = $clog2(LineDepth + 1);

  // configuration fields
  localparam int CfgW  = 12;
  localparam int ChW   = 3;
  localparam int IdxW  = 2;
  localparam int PixW  = 8;

  localparam logic [CfgW-1:0] WidthReset    = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset   = CfgW'(480);
  localparam logic [ChW-1:0]  ChannelsReset = ChW'(1);

  // smallest frame dimension the filter works on
  localparam int MinDim = 3;

  typedef enum logic [IdxW-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_e;

  // line buffer read addresses for one sample
  typedef struct packed {
    logic [AddrW-1:0] centre_addr;
    logic [AddrW-1:0] right_addr;
    logic [AddrW-1:0] left_addr;
  } line_addr_t;

  // neighbourhood taps read from the line buffers
  typedef struct packed {
    logic [PixW-1:0] centre;
    logic [PixW-1:0] right;
    logic [PixW-1:0] left;
    logic [PixW-1:0] up;
  } taps_t;

endpackage

/* rtl/shp3_lines.sv */
// two line buffers with registered reads and forwarding of the delayed row copy
module shp3_lines (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  shp3_pkg::line_addr_t   addr_i,
  input  logic [shp3_pkg::PixW-1:0] down_i,
  output shp3_pkg::taps_t        taps_o
);
  import shp3_pkg::*;

  logic [PixW-1:0] middle_mem [LineDepth];
  logic [PixW-1:0] older_mem  [LineDepth];

  logic [PixW-1:0]  centre_q, right_q, left_q, up_q;
  logic             wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;
  logic             fwd_left, fwd_up;

  // the row above moves into the older line in the cycle after its value is read
  assign fwd_left = wr_pend_q && (wr_addr_q == addr_i.left_addr);
  assign fwd_up   = wr_pend_q && (wr_addr_q == addr_i.centre_addr);

  // middle line: new sample in, old centre and right neighbour out
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      middle_mem[addr_i.centre_addr] <= down_i;
      centre_q <= middle_mem[addr_i.centre_addr];
      right_q  <= middle_mem[addr_i.right_addr];
    end
  end

  // older line: delayed copy of the middle line, left and up taps out
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      older_mem[wr_addr_q] <= centre_q;
    end
    if (fire_i) begin
      left_q <= fwd_left ? centre_q : older_mem[addr_i.left_addr];
      up_q   <= fwd_up   ? centre_q : older_mem[addr_i.centre_addr];
    end
  end

  // pending copy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      wr_addr_q <= addr_i.centre_addr;
    end
  end

  assign taps_o = '{centre: centre_q, right: right_q, left: left_q, up: up_q};

endmodule

/* rtl/sharpen_3x3_stream.sv */
// top level of the streaming 3x3 sharpen filter
// path: a sample passes through stage 1 and the result register before its result is offered
// throughput: one sample per cycle while the output does not stall, set by one write
//   to each line buffer per sample; on the last row each sample gives two results, so
//   the output port holds back the next sample there until both results are taken
// reset: position goes to row 0 sample 0, registers to 640x480 with one channel;
//   line buffer contents are undefined until written, no clearing pass
module sharpen_3x3_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [shp3_pkg::PixW-1:0]    sample_i,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  output logic [shp3_pkg::PixW-1:0]    out_sample_o,
  output logic                         end_of_frame_o,
  output logic                         last_of_run_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [shp3_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [shp3_pkg::CfgW-1:0]    cfg_data_i
);
  import shp3_pkg::*;

  typedef struct packed {
    logic has_res;
    logic interior;
    logic last_row;
    logic eof;
  } item_flags_t;

  // configuration registers
  logic [CfgW-1:0] width_q, height_q;
  logic [ChW-1:0]  chans_q;

  // position state
  logic [AddrW-1:0] pos_s_q;
  logic [CfgW-1:0]  pos_r_q;

  // effective geometry
  logic [LenW-1:0] eff_w, row_len, chans_len;
  logic [CfgW-1:0] eff_h;
  logic [ChW-1:0]  eff_ch;

  // position after wrap and after advance
  logic [LenW-1:0] s_n, s_nx;
  logic [CfgW-1:0] r_t, r_n, r_nx;
  logic [AddrW-1:0] s_cur;

  line_addr_t  addr;
  item_flags_t flags_d;
  taps_t       taps;

  // stage 1
  logic            s1_valid_q;
  item_flags_t     s1_flags_q;
  logic [PixW-1:0] down_q;

  // result stage
  logic            out_valid_q, phase_q, two_q, eof_q;
  logic [PixW-1:0] val_q;
  logic [PixW-1:0] val_d;

  logic in_fire, out_fire, s2_free, s1_go;
  logic signed [11:0] c12, rt12, l12, u12, d12, acc;

  // configuration write port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      chans_q  <= ChannelsReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:    width_q  <= cfg_data_i;
        REG_HEIGHT:   height_q <= cfg_data_i;
        REG_CHANNELS: chans_q  <= cfg_data_i[ChW-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    if ({{(LenW-CfgW){1'b0}}, width_q} < LenW'(MinDim)) begin
      eff_w = LenW'(MinDim);
    end else if ({{(LenW-CfgW){1'b0}}, width_q} > LenW'(MaxWidth)) begin
      eff_w = LenW'(MaxWidth);
    end else begin
      eff_w = {{(LenW-CfgW){1'b0}}, width_q};
    end
    eff_h = (height_q < CfgW'(MinDim)) ? CfgW'(MinDim) : height_q;
    if (chans_q == '0) begin
      eff_ch = ChW'(1);
    end else if (chans_q > ChW'(MaxChannels)) begin
      eff_ch = ChW'(MaxChannels);
    end else begin
      eff_ch = chans_q;
    end
    chans_len = {{(LenW-ChW){1'b0}}, eff_ch};
    row_len   = LenW'(eff_w * chans_len);
  end

  // wrap a stale position, then work out flags, addresses and the next position
  always_comb begin
    if ({1'b0, pos_s_q} >= row_len) begin
      s_n = '0;
      r_t = pos_r_q + CfgW'(1);
    end else begin
      s_n = {1'b0, pos_s_q};
      r_t = pos_r_q;
    end
    r_n   = (r_t >= eff_h) ? '0 : r_t;
    s_cur = s_n[AddrW-1:0];

    addr.centre_addr = s_cur;
    addr.right_addr  = s_cur + chans_len[AddrW-1:0];
    addr.left_addr   = s_cur - chans_len[AddrW-1:0];

    flags_d.has_res  = (r_n != '0);
    flags_d.interior = (r_n >= CfgW'(2)) && (s_n >= chans_len) && (s_n < row_len - chans_len);
    flags_d.last_row = (r_n == eff_h - CfgW'(1));
    flags_d.eof      = (s_n == row_len - LenW'(1));

    s_nx = s_n + LenW'(1);
    r_nx = r_n;
    if (s_nx >= row_len) begin
      s_nx = '0;
      r_nx = r_n + CfgW'(1);
      if (r_nx >= eff_h) begin
        r_nx = '0;
      end
    end
  end

  // handshake
  assign out_fire       = out_valid_q && !out_stall_i;
  assign s2_free        = !out_valid_q || (out_fire && (phase_q || !two_q));
  assign s1_go          = s1_valid_q && (!s1_flags_q.has_res || s2_free);
  assign sample_stall_o = s1_valid_q && !s1_go;
  assign in_fire        = sample_valid_i && !sample_stall_o;

  // position register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_s_q <= '0;
      pos_r_q <= '0;
    end else if (in_fire) begin
      pos_s_q <= s_nx[AddrW-1:0];
      pos_r_q <= r_nx;
    end
  end

  shp3_lines u_lines (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .addr_i (addr),
    .down_i (sample_i),
    .taps_o (taps)
  );

  // stage 1 control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_flags_q <= flags_d;
      down_q     <= sample_i;
    end
  end

  // 5 x centre minus the four neighbours, saturated; zero outside the interior
  always_comb begin
    c12  = $signed({4'b0, taps.centre});
    rt12 = $signed({4'b0, taps.right});
    l12  = $signed({4'b0, taps.left});
    u12  = $signed({4'b0, taps.up});
    d12  = $signed({4'b0, down_q});
    acc  = (c12 <<< 2) + c12 - l12 - rt12 - u12 - d12;
    if (!s1_flags_q.interior || acc < 0) begin
      val_d = '0;
    end else if (acc > 12'sd255) begin
      val_d = 8'hff;
    end else begin
      val_d = acc[PixW-1:0];
    end
  end

  // result register, second phase carries the zero bottom-row sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (s1_go && s1_flags_q.has_res) begin
      out_valid_q <= 1'b1;
      phase_q     <= 1'b0;
    end else if (out_fire) begin
      if (two_q && !phase_q) begin
        phase_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_flags_q.has_res) begin
      val_q <= val_d;
      two_q <= s1_flags_q.last_row;
      eof_q <= s1_flags_q.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = phase_q ? '0 : val_q;
  assign end_of_frame_o = phase_q && eof_q;
  assign last_of_run_o  = phase_q || !two_q;

endmodule
